// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("itp assertion failed");

// Next-cycle implication, disabled while reset is low
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("itp assertion failed");

`endif

// ----- sv/itp_pkg.sv -----
// Types, character codes and helper functions of the infix to postfix converter
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

  localparam int unsigned DefStackDepth = 32;
  localparam int unsigned CharW         = 8;

  // Character codes
  localparam logic [CharW-1:0] ChMul   = 8'h2a;  // '*'
  localparam logic [CharW-1:0] ChDiv   = 8'h2f;  // '/'
  localparam logic [CharW-1:0] ChMod   = 8'h25;  // '%'
  localparam logic [CharW-1:0] ChAdd   = 8'h2b;  // '+'
  localparam logic [CharW-1:0] ChSub   = 8'h2d;  // '-'
  localparam logic [CharW-1:0] ChLt    = 8'h3c;  // '<'
  localparam logic [CharW-1:0] ChGt    = 8'h3e;  // '>'
  localparam logic [CharW-1:0] ChOpen  = 8'h28;  // '('
  localparam logic [CharW-1:0] ChClose = 8'h29;  // ')'
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChLowZ  = 8'h7a;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpZ   = 8'h5a;
  localparam logic [CharW-1:0] ChDig0  = 8'h30;
  localparam logic [CharW-1:0] ChDig9  = 8'h39;

  // Precedence levels
  localparam logic [2:0] PrecMul   = 3'd6;
  localparam logic [2:0] PrecAdd   = 3'd5;
  localparam logic [2:0] PrecCmp   = 3'd4;
  localparam logic [2:0] PrecOther = 3'd0;

  typedef struct packed {
    logic [CharW-1:0] in_char;
    logic             end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             last_of_run;
    logic             expression_done;
    logic             stack_overflow;
  } out_item_t;

  // Request from the sequencer to the output stage
  typedef struct packed {
    logic             push;   // new result into the holding slot
    logic             close;  // release the held result as the last of the run
    logic [CharW-1:0] ch;
    logic             done;
    logic             ovf;
  } res_req_t;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StCheck,
    StPush,
    StFinish
  } state_e;

  typedef enum logic [1:0] {
    KindOperand,
    KindOpen,
    KindClose,
    KindOper
  } kind_e;

  function automatic logic [2:0] prec_of(input logic [CharW-1:0] c);
    logic [2:0] p;
    if (c inside {ChMul, ChDiv, ChMod}) begin
      p = PrecMul;
    end else if (c inside {ChAdd, ChSub}) begin
      p = PrecAdd;
    end else if (c inside {ChLt, ChGt}) begin
      p = PrecCmp;
    end else begin
      p = PrecOther;
    end
    return p;
  endfunction

  function automatic logic is_operand(input logic [CharW-1:0] c);
    return c inside {[ChLowA:ChLowZ], [ChUpA:ChUpZ], [ChDig0:ChDig9]};
  endfunction

endpackage

`default_nettype wire

// ----- sv/infix_to_postfix_converter.sv -----
// Top level of the infix to postfix converter
// Infix to postfix converter (shunting-yard). One character is taken per request
// and the postfix characters it releases come out one per request on the output
// channel; the final one of each run carries last_of_run, and with end_of_input
// it also carries expression_done. The operator stack sits in a RAM of
// StackDepth entries with a registered read, so every pop is a read in StRead
// followed by a check and emit in StCheck; a stalled consumer holds each pop in
// StCheck until there is room again. Only one character is in work at a time;
// the output register lets the consumer stall without losing results. A push
// onto a full stack is dropped and stack_overflow stays set on results until
// the expression ends. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter import itp_pkg::*; #(
  parameter int unsigned StackDepth = DefStackDepth
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  localparam int unsigned AddrW = $clog2(StackDepth);

  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [CharW-1:0] rd_data;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [CharW-1:0] wr_data;
  res_req_t         res_req;
  logic             room;

  // Operator stack storage
  itp_ram #(
    .Width (CharW),
    .Depth (StackDepth)
  ) u_stack_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Sequencer
  itp_ctrl #(
    .StackDepth (StackDepth)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .res_o      (res_req),
    .room_i     (room)
  );

  // Result holding and output register
  itp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res_req),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ----- sv/itp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module itp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- sv/itp_ctrl.sv -----
// Sequencer: classifies characters, pops and pushes the operator stack in RAM
`timescale 1ns / 1ps
`default_nettype none

module itp_ctrl import itp_pkg::*; #(
  parameter int unsigned StackDepth = DefStackDepth,
  localparam int unsigned AddrW = $clog2(StackDepth),
  localparam int unsigned CntW  = $clog2(StackDepth + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_item_t         in_item_i,
  // stack RAM
  output logic                  rd_en_o,
  output logic      [AddrW-1:0] rd_addr_o,
  input  wire logic [CharW-1:0] rd_data_i,
  output logic                  wr_en_o,
  output logic      [AddrW-1:0] wr_addr_o,
  output logic      [CharW-1:0] wr_data_o,
  // output stage
  output res_req_t              res_o,
  input  wire logic             room_i
);

  state_e           state_q, state_d;
  kind_e            kind_q, kind_d;
  logic [CharW-1:0] ch_q, ch_d;
  logic             last_q, last_d;
  logic             flush_q, flush_d;
  logic             ovf_q, ovf_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  cnt_m1;
  logic             top_stops;

  assign cnt_m1    = cnt_q - CntW'(1);
  assign rd_addr_o = cnt_m1[AddrW-1:0];
  assign wr_addr_o = cnt_q[AddrW-1:0];
  assign wr_data_o = ch_q;

  // An ordinary operator stops popping at '(' or a looser operator
  assign top_stops = (rd_data_i == ChOpen) || (prec_of(ch_q) > prec_of(rd_data_i));

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      kind_q  <= KindOperand;
      last_q  <= 1'b0;
      flush_q <= 1'b0;
      ovf_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      last_q  <= last_d;
      flush_q <= flush_d;
      ovf_q   <= ovf_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d;
  end

  // Next state and outputs
  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    ch_d       = ch_q;
    last_d     = last_q;
    flush_d    = flush_q;
    ovf_d      = ovf_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    rd_en_o    = 1'b0;
    wr_en_o    = 1'b0;
    res_o      = '0;
    res_o.ch   = rd_data_i;
    res_o.done = last_q;
    res_o.ovf  = ovf_q;

    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ch_d    = in_item_i.in_char;
          last_d  = in_item_i.end_of_input;
          flush_d = 1'b0;
          if (is_operand(in_item_i.in_char)) begin
            kind_d     = KindOperand;
            res_o.push = 1'b1;
            res_o.ch   = in_item_i.in_char;
            if (in_item_i.end_of_input) begin
              flush_d = 1'b1;
              state_d = StRead;
            end else begin
              state_d = StFinish;
            end
          end else if (in_item_i.in_char == ChOpen) begin
            kind_d  = KindOpen;
            state_d = StPush;
          end else if (in_item_i.in_char == ChClose) begin
            kind_d  = KindClose;
            state_d = StRead;
          end else begin
            kind_d  = KindOper;
            state_d = StRead;
          end
        end
      end

      // Fetch the top entry; on an empty stack leave the loop or start the final flush
      StRead: begin
        if (cnt_q == '0) begin
          if (flush_q) begin
            state_d = StFinish;
          end else if (kind_q == KindOper) begin
            state_d = StPush;
          end else if (last_q) begin
            flush_d = 1'b1;
          end else begin
            state_d = StFinish;
          end
        end else begin
          rd_en_o = 1'b1;
          state_d = StCheck;
        end
      end

      // Top entry is on the read port
      StCheck: begin
        if (!flush_q && kind_q == KindClose && rd_data_i == ChOpen) begin
          // matching '(' is discarded
          cnt_d = cnt_m1;
          if (last_q) begin
            flush_d = 1'b1;
            state_d = StRead;
          end else begin
            state_d = StFinish;
          end
        end else if (!flush_q && kind_q == KindOper && top_stops) begin
          state_d = StPush;
        end else if (room_i) begin
          res_o.push = 1'b1;
          cnt_d      = cnt_m1;
          state_d    = StRead;
        end
      end

      // Push the held character; a full stack drops it
      StPush: begin
        if (cnt_q < CntW'(StackDepth)) begin
          wr_en_o = 1'b1;
          cnt_d   = cnt_q + CntW'(1);
        end else begin
          ovf_d = 1'b1;
        end
        if (last_q) begin
          flush_d = 1'b1;
          state_d = StRead;
        end else begin
          state_d = StFinish;
        end
      end

      // Release the held result as the last of this run
      StFinish: begin
        if (room_i) begin
          res_o.close = 1'b1;
          if (last_q) begin
            ovf_d = 1'b0;
          end
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/itp_out_stage.sv -----
// Output stage: one-result holding slot for the last mark plus output register
`timescale 1ns / 1ps
`default_nettype none

module itp_out_stage import itp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire res_req_t  res_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  logic             pend_v_q, pend_v_d;
  logic [CharW-1:0] pend_ch_q, pend_ch_d;
  logic             out_v_q, out_v_d;
  out_item_t        out_q, out_d;
  logic             move_ok;

  assign move_ok = !out_v_q || out_ready_i;
  assign room_o  = !pend_v_q || move_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_ch_q <= pend_ch_d;
    out_q     <= out_d;
  end

  // A held result moves on once its successor is known or the run closes
  always_comb begin
    pend_v_d  = pend_v_q;
    pend_ch_d = pend_ch_q;
    out_v_d   = out_v_q && !out_ready_i;
    out_d     = out_q;
    if (res_i.push && room_o) begin
      if (pend_v_q) begin
        out_d.out_char        = pend_ch_q;
        out_d.last_of_run     = 1'b0;
        out_d.expression_done = 1'b0;
        out_d.stack_overflow  = res_i.ovf;
        out_v_d               = 1'b1;
      end
      pend_ch_d = res_i.ch;
      pend_v_d  = 1'b1;
    end else if (res_i.close && room_o && pend_v_q) begin
      out_d.out_char        = pend_ch_q;
      out_d.last_of_run     = 1'b1;
      out_d.expression_done = res_i.done;
      out_d.stack_overflow  = res_i.ovf;
      out_v_d               = 1'b1;
      pend_v_d              = 1'b0;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ----- sv/itp_checker.sv -----
// Port-level checker for the infix to postfix converter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module itp_checker import itp_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_item_o
);

  // Stalled result stays offered
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  // Stalled result keeps its payload
  `ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_item_o))
  // End of expression only on the last result of a run
  `ASSERT_IMP(a_done_last, clk_i, rst_ni, out_valid_o && out_item_o.expression_done,
              out_item_o.last_of_run)
  // One character in work at a time
  `ASSERT_NXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // While a non-final result waits, its run is still in work
  `ASSERT_IMP(a_run_open, clk_i, rst_ni, out_valid_o && !out_item_o.last_of_run, !in_ready_o)

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
